// ----- rtl/core/dkg_pkg.sv -----
package dkg_pkg;

    // Register lengths of the two nonlinear shift registers
    localparam int SHORT_LEN = 33;
    localparam int LONG_LEN  = 95;

    // Key and IV sizes
    localparam int KEY_BITS = 128;
    localparam int IV_BITS  = 96;

    // IV position runs 0..IV_BITS (period 97), key position is time mod 32
    localparam int IVPOS_W  = 7;
    localparam int KEYPOS_W = 5;

    // Position pair that marks time 256, the end of the IV-only window
    localparam logic [IVPOS_W-1:0]  IVPOS_WINDOW_END  = 7'd62;
    localparam logic [KEYPOS_W-1:0] KEYPOS_WINDOW_END = 5'd0;

    // Keystream word and its bit count
    localparam int WORD_BITS = 32;
    localparam int COUNT_W   = 6;
    localparam int POS_W     = 5;

    // Configuration port
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_KEY_HIGH = 3'd0,
        REG_KEY_LOW  = 3'd1,
        REG_IV_HIGH  = 3'd2,
        REG_IV_LOW   = 3'd3
    } cfg_reg_t;

    // Item opcodes
    localparam logic OP_INIT     = 1'b0;
    localparam logic OP_GENERATE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DELIVER
    } seq_state_t;

    // Control from the sequencer to the register unit
    typedef struct packed {
        logic load;   // load both registers from the key, clear positions
        logic step;   // one register clock
        logic warm;   // feed the output bit back (warm-up clocks)
    } nlfsr_ctrl_t;

endpackage

// ----- rtl/core/dkg_nlfsr.sv -----
module dkg_nlfsr
    import dkg_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  nlfsr_ctrl_t         ctrl,
    input  logic [KEY_BITS-1:0] key,   // key bit 0 in the MSB
    input  logic [IV_BITS-1:0]  iv,    // IV bit 0 in the MSB
    output logic                ks_bit // output bit seen before the next clock
);

    logic [SHORT_LEN-1:0] short_reg, short_next;
    logic [LONG_LEN-1:0]  long_reg, long_next;
    logic [IVPOS_W-1:0]   ivpos_reg, ivpos_next;
    logic [KEYPOS_W-1:0]  keypos_reg, keypos_next;
    logic                 past_reg, past_next;

    logic [SHORT_LEN-1:0] s;
    logic [LONG_LEN-1:0]  l;
    logic                 f1, f2, out_bit, iv_b, key_b, inj, fb, n1, n2;
    logic [6:0]           iv_idx, key_idx;

    assign s = short_reg;
    assign l = long_reg;

    // Short register feedback, with the all-zero escape on bits 1..32
    always_comb
    begin
        f1 = s[0] ^ s[2] ^ s[7] ^ s[9] ^ s[10] ^ s[15] ^ s[23] ^ s[25] ^ s[30]
            ^ (s[8] & s[15]) ^ (s[12] & s[16]) ^ (s[13] & s[15]) ^ (s[13] & s[25])
            ^ (s[1] & s[8] & s[14]) ^ (s[1] & s[8] & s[18]) ^ (s[8] & s[12] & s[16])
            ^ (s[8] & s[14] & s[18]) ^ (s[8] & s[15] & s[16]) ^ (s[8] & s[15] & s[17])
            ^ (s[15] & s[24] & s[17])
            ^ (s[1] & s[8] & s[14] & s[17]) ^ (s[1] & s[8] & s[17] & s[18])
            ^ (s[1] & s[14] & s[24] & s[17]) ^ (s[1] & s[18] & s[24] & s[17])
            ^ (s[8] & s[12] & s[16] & s[17]) ^ (s[8] & s[14] & s[17] & s[18])
            ^ (s[8] & s[15] & s[16] & s[17]) ^ (s[12] & s[16] & s[24] & s[17])
            ^ (s[14] & s[24] & s[17] & s[18]) ^ (s[15] & s[16] & s[24] & s[17])
            ^ ~(|s[SHORT_LEN-1:1]);
    end

    // Long register feedback
    always_comb
    begin
        f2 = l[0] ^ l[26] ^ l[56] ^ l[89] ^ l[94]
            ^ (l[3] & l[67]) ^ (l[11] & l[13]) ^ (l[17] & l[18]) ^ (l[27] & l[59])
            ^ (l[36] & l[39]) ^ (l[40] & l[48]) ^ (l[50] & l[79]) ^ (l[54] & l[71])
            ^ (l[58] & l[63]) ^ (l[61] & l[65]) ^ (l[68] & l[84])
            ^ (l[8] & l[46] & l[87]) ^ (l[22] & l[24] & l[25])
            ^ (l[70] & l[78] & l[82]) ^ (l[86] & l[90] & l[91] & l[93]);
    end

    // Output filter
    always_comb
    begin
        out_bit = l[7] ^ l[15] ^ l[32] ^ l[47] ^ l[66] ^ l[80] ^ l[92]
            ^ (l[5] & l[85]) ^ (l[12] & l[74]) ^ (l[20] & l[69]) ^ (l[34] & l[57])
            ^ l[53] ^ (l[38] & l[44]) ^ (l[23] & l[49] & l[83])
            ^ (l[6] & l[33] & l[51] & l[73])
            ^ (l[4] & l[29] & l[43] & l[60] & l[81])
            ^ (l[9] & l[14] & l[35] & l[42] & l[55] & l[77])
            ^ (l[1] & l[16] & l[28] & l[45] & l[64] & l[75] & l[88])
            ^ s[26] ^ (s[5] & s[19]) ^ (s[11] & s[22] & s[31])
            ^ l[76] ^ (s[3] & l[10]) ^ (s[20] & l[21] & l[30])
            ^ (s[6] & s[29] & l[62] & l[72]);
    end

    assign ks_bit = out_bit;

    // Key/IV injection: IV bit (pos-1) sits at iv[96-pos]; key bit k at key[127-k]
    assign iv_idx  = 7'(IV_BITS) - ivpos_reg;
    assign key_idx = 7'(KEY_BITS - 1) - {2'b00, keypos_reg};
    assign iv_b    = (ivpos_reg == '0) ? 1'b0 : iv[iv_idx];
    assign key_b   = key[key_idx];
    assign inj     = past_reg ? (key_b ^ iv_b) : iv_b;

    assign fb = ctrl.warm & out_bit;
    assign n1 = f1 ^ fb;
    assign n2 = f2 ^ s[0] ^ inj ^ fb;

    // Next state: key load, one clock, or hold
    always_comb
    begin
        short_next  = short_reg;
        long_next   = long_reg;
        ivpos_next  = ivpos_reg;
        keypos_next = keypos_reg;
        past_next   = past_reg;
        if (ctrl.load)
        begin
            for (int i = 0; i < LONG_LEN; i++)
            begin
                long_next[i] = key[KEY_BITS-1-i];
            end
            long_next[0] = ~key[KEY_BITS-1];
            for (int i = 0; i < SHORT_LEN; i++)
            begin
                short_next[i] = key[KEY_BITS-1-LONG_LEN-i];
            end
            ivpos_next  = '0;
            keypos_next = '0;
            past_next   = 1'b0;
        end
        else if (ctrl.step)
        begin
            long_next   = {n2, long_reg[LONG_LEN-1:1]};
            short_next  = {n1, short_reg[SHORT_LEN-1:1]};
            ivpos_next  = (ivpos_reg >= 7'(IV_BITS)) ? '0 : ivpos_reg + 7'd1;
            keypos_next = keypos_reg + 5'd1;
            if (ivpos_next == IVPOS_WINDOW_END && keypos_next == KEYPOS_WINDOW_END)
            begin
                past_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_reg  <= '0;
            long_reg   <= '0;
            ivpos_reg  <= '0;
            keypos_reg <= '0;
            past_reg   <= 1'b0;
        end
        else
        begin
            short_reg  <= short_next;
            long_reg   <= long_next;
            ivpos_reg  <= ivpos_next;
            keypos_reg <= keypos_next;
            past_reg   <= past_next;
        end
    end

endmodule

// ----- rtl/core/draco_keystream_generator_top.sv -----
// Channel  | Handshake              | Payload
// ---------+------------------------+------------------------------------------
// input    | in_valid / in_stall    | op, bit_count
// output   | out_valid / out_stall  | keystream_word, bits_produced, init_done
// config   | cfg_write_en           | cfg_index, cfg_data
//
// One register clock per cycle through the shared feedback unit while a transaction
// runs: an initialize transaction loads the key and runs the warm-up, a generate one
// clocks out n keystream bits (n = bit_count saturated to 32). The result moves via
// the deliver state to the output register before the next input is taken.
// The input is stalled from acceptance until the result is in the output register.
// A stalled output holds its result; the next input may be taken meanwhile.
// Reset clears the key, IV, both registers and the time counters.
module draco_keystream_generator_top
    import dkg_pkg::*;
#(
    parameter int INIT_CLOCKS = 512
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // input channel
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   op,
    input  logic [COUNT_W-1:0]     bit_count,
    // output channel
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [WORD_BITS-1:0]   keystream_word,
    output logic [COUNT_W-1:0]     bits_produced,
    output logic                   init_done,
    // configuration
    input  logic                   cfg_write_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int CNT_W = $clog2(INIT_CLOCKS + 1);

    // Configuration registers
    logic [63:0] key_high_reg, key_low_reg, iv_high_reg;
    logic [31:0] iv_low_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            iv_high_reg  <= '0;
            iv_low_reg   <= '0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_KEY_HIGH: key_high_reg <= cfg_data;
                REG_KEY_LOW:  key_low_reg  <= cfg_data;
                REG_IV_HIGH:  iv_high_reg  <= cfg_data;
                REG_IV_LOW:   iv_low_reg   <= cfg_data[31:0];
                default:      ;
            endcase
        end
    end

    // Sequencer state
    seq_state_t           state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [WORD_BITS-1:0] word_reg, word_next;
    logic [COUNT_W-1:0]   n_reg, n_next;
    logic                 gen_reg, gen_next;

    // Output register
    logic                 out_valid_reg, out_valid_next;
    logic [WORD_BITS-1:0] out_word_reg, out_word_next;
    logic [COUNT_W-1:0]   out_count_reg, out_count_next;
    logic                 out_init_reg, out_init_next;

    nlfsr_ctrl_t          ctrl;
    logic                 ks_bit;
    logic                 accept;
    logic                 out_free;
    logic [COUNT_W-1:0]   n_sat;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign n_sat    = (bit_count > COUNT_W'(WORD_BITS)) ? COUNT_W'(WORD_BITS) : bit_count;

    // Next state and register unit control
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        pos_next       = pos_reg;
        word_next      = word_reg;
        n_next         = n_reg;
        gen_next       = gen_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_word_next  = out_word_reg;
        out_count_next = out_count_reg;
        out_init_next  = out_init_reg;
        ctrl           = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    gen_next   = (op == OP_GENERATE);
                    word_next  = '0;
                    pos_next   = POS_W'(WORD_BITS - 1);
                    state_next = ST_RUN;
                    if (op == OP_GENERATE)
                    begin
                        n_next   = n_sat;
                        cnt_next = CNT_W'(n_sat);
                    end
                    else
                    begin
                        n_next    = '0;
                        cnt_next  = CNT_W'(INIT_CLOCKS);
                        ctrl.load = 1'b1;
                    end
                end
            end
            ST_RUN:
            begin
                if (cnt_reg != '0)
                begin
                    ctrl.step = 1'b1;
                    ctrl.warm = !gen_reg;
                    cnt_next  = cnt_reg - CNT_W'(1);
                    if (gen_reg)
                    begin
                        word_next[pos_reg] = ks_bit;
                        pos_next           = pos_reg - POS_W'(1);
                    end
                end
                else
                begin
                    state_next = ST_DELIVER;
                end
            end
            ST_DELIVER:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = word_reg;
                    out_count_next = n_reg;
                    out_init_next  = !gen_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            pos_reg       <= '0;
            gen_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pos_reg       <= pos_next;
            gen_reg       <= gen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        word_reg      <= word_next;
        n_reg         <= n_next;
        out_word_reg  <= out_word_next;
        out_count_reg <= out_count_next;
        out_init_reg  <= out_init_next;
    end

    dkg_nlfsr u_nlfsr (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .key    ({key_high_reg, key_low_reg}),
        .iv     ({iv_high_reg, iv_low_reg}),
        .ks_bit (ks_bit)
    );

    assign out_valid      = out_valid_reg;
    assign keystream_word = out_word_reg;
    assign bits_produced  = out_count_reg;
    assign init_done      = out_init_reg;

endmodule

// ----- rtl/core/dkg_checker.sv -----
module dkg_checker
    import dkg_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_stall,
    input  logic                   out_valid,
    input  logic                   out_stall,
    input  logic [WORD_BITS-1:0]   keystream_word,
    input  logic [COUNT_W-1:0]     bits_produced,
    input  logic                   init_done
);

    // An accepted transaction keeps the input stalled in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after acceptance");

    // Initialize results carry no keystream
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && init_done) |-> (keystream_word == '0 && bits_produced == '0))
    else $error("initialize result carries keystream bits");

    // Generate results never exceed one word, unused low bits are zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !init_done) |->
            (bits_produced <= COUNT_W'(WORD_BITS)
             && (keystream_word << bits_produced) == '0))
    else $error("keystream word padding or count wrong");

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(keystream_word) && $stable(bits_produced)
             && $stable(init_done)))
    else $error("stalled result changed");

endmodule

bind draco_keystream_generator_top dkg_checker u_dkg_checker (.*);

// ----- verif/draco_keystream_generator_top_tb.sv -----
module draco_keystream_generator_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dkg_pkg::*;

    localparam int INIT_CLOCKS   = 512;
    localparam int QUIET_LIMIT   = 4000;   // cycles with no transaction or register write
    localparam int HOLD_CYCLES   = 200;    // long receiver hold-off
    localparam int REPORT_LIMIT  = 100;
    localparam int RANDOM_TARGET = 1650;
    localparam int STEADY_ITEMS  = 100;
    localparam int COUNT_MAX     = (1 << COUNT_W) - 1;

    // indexes past the register list, which the block must ignore
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_FIRST = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LAST  = 3'd7;

    typedef struct packed {
        logic [WORD_BITS-1:0] word;
        logic [COUNT_W-1:0]   count;
        logic                 done;
    } keystream_result_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic                   op;
    logic [COUNT_W-1:0]     bit_count;
    logic                   out_valid;
    logic                   out_stall;
    logic [WORD_BITS-1:0]   keystream_word;
    logic [COUNT_W-1:0]     bits_produced;
    logic                   init_done;
    logic                   cfg_write_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // cipher state mirrored by the predictor
    logic [SHORT_LEN-1:0] sreg;
    logic [LONG_LEN-1:0]  lreg;
    logic [IVPOS_W-1:0]   ivpos;
    logic [KEYPOS_W-1:0]  keypos;
    logic                 past_window;
    logic [63:0]          key_hi_m;
    logic [63:0]          key_lo_m;
    logic [63:0]          iv_hi_m;
    logic [31:0]          iv_lo_m;

    keystream_result_t pending_keystream[$];
    keystream_result_t next_expected;

    int unsigned fail_count     = 0;
    int unsigned items_sent     = 0;
    int unsigned init_items     = 0;
    int unsigned gen_items      = 0;
    int unsigned results_seen   = 0;
    int unsigned reg_writes     = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned hold_asked     = 0;
    int unsigned hold_done      = 0;
    bit          idle_on        = 1'b0;

    draco_keystream_generator_top #(
        .INIT_CLOCKS(INIT_CLOCKS)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .bit_count      (bit_count),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .keystream_word (keystream_word),
        .bits_produced  (bits_produced),
        .init_done      (init_done),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // key bit 0 sits in the MSB of key_high
    function automatic logic key_bit(input int unsigned i);
        i = i & 127;
        if (i < 64)
            return key_hi_m[63 - i];
        return key_lo_m[127 - i];
    endfunction

    function automatic logic iv_bit(input int unsigned i);
        if (i < 64)
            return iv_hi_m[63 - i];
        if (i < IV_BITS)
            return iv_lo_m[95 - i];
        return 1'b0;
    endfunction

    function automatic logic short_feedback(input logic [SHORT_LEN-1:0] s);
        logic all_zero;
        // escape term keeps the short register out of the all-zero lockup
        all_zero = (s[SHORT_LEN-1:1] == '0);
        return s[0] ^ s[2] ^ s[7] ^ s[9] ^ s[10] ^ s[15] ^ s[23] ^ s[25] ^ s[30]
            ^ (s[8] & s[15]) ^ (s[12] & s[16]) ^ (s[13] & s[15]) ^ (s[13] & s[25])
            ^ (s[1] & s[8] & s[14]) ^ (s[1] & s[8] & s[18]) ^ (s[8] & s[12] & s[16])
            ^ (s[8] & s[14] & s[18]) ^ (s[8] & s[15] & s[16]) ^ (s[8] & s[15] & s[17])
            ^ (s[15] & s[24] & s[17])
            ^ (s[1] & s[8] & s[14] & s[17]) ^ (s[1] & s[8] & s[17] & s[18])
            ^ (s[1] & s[14] & s[24] & s[17]) ^ (s[1] & s[18] & s[24] & s[17])
            ^ (s[8] & s[12] & s[16] & s[17]) ^ (s[8] & s[14] & s[17] & s[18])
            ^ (s[8] & s[15] & s[16] & s[17]) ^ (s[12] & s[16] & s[24] & s[17])
            ^ (s[14] & s[24] & s[17] & s[18]) ^ (s[15] & s[16] & s[24] & s[17])
            ^ all_zero;
    endfunction

    function automatic logic long_feedback(input logic [LONG_LEN-1:0] l);
        return l[0] ^ l[26] ^ l[56] ^ l[89] ^ l[94]
            ^ (l[3] & l[67]) ^ (l[11] & l[13]) ^ (l[17] & l[18]) ^ (l[27] & l[59])
            ^ (l[36] & l[39]) ^ (l[40] & l[48]) ^ (l[50] & l[79]) ^ (l[54] & l[71])
            ^ (l[58] & l[63]) ^ (l[61] & l[65]) ^ (l[68] & l[84])
            ^ (l[8] & l[46] & l[87]) ^ (l[22] & l[24] & l[25])
            ^ (l[70] & l[78] & l[82]) ^ (l[86] & l[90] & l[91] & l[93]);
    endfunction

    function automatic logic keystream_bit(input logic [LONG_LEN-1:0] l,
                                           input logic [SHORT_LEN-1:0] s);
        logic lin, quad, t1, t2, t3;
        lin  = l[7] ^ l[15] ^ l[32] ^ l[47] ^ l[66] ^ l[80] ^ l[92];
        quad = (l[5] & l[85]) ^ (l[12] & l[74]) ^ (l[20] & l[69]) ^ (l[34] & l[57]);
        t1   = l[53] ^ (l[38] & l[44]) ^ (l[23] & l[49] & l[83])
            ^ (l[6] & l[33] & l[51] & l[73])
            ^ (l[4] & l[29] & l[43] & l[60] & l[81])
            ^ (l[9] & l[14] & l[35] & l[42] & l[55] & l[77])
            ^ (l[1] & l[16] & l[28] & l[45] & l[64] & l[75] & l[88]);
        t2   = s[26] ^ (s[5] & s[19]) ^ (s[11] & s[22] & s[31]);
        t3   = l[76] ^ (s[3] & l[10]) ^ (s[20] & l[21] & l[30])
            ^ (s[6] & s[29] & l[62] & l[72]);
        return lin ^ quad ^ t1 ^ t2 ^ t3;
    endfunction

    // one register clock, returns the bit seen before the shift
    function automatic logic clock_registers(input logic warm);
        logic f1, f2, o, fb, ivb, inj, n1, n2;
        f1  = short_feedback(sreg);
        f2  = long_feedback(lreg);
        o   = keystream_bit(lreg, sreg);
        fb  = warm & o;
        ivb = (ivpos == '0) ? 1'b0 : iv_bit(int'(ivpos) - 1);
        inj = past_window ? (key_bit(int'(keypos)) ^ ivb) : ivb;
        n2  = f2 ^ sreg[0] ^ inj ^ fb;
        n1  = f1 ^ fb;
        lreg   = {n2, lreg[LONG_LEN-1:1]};
        sreg   = {n1, sreg[SHORT_LEN-1:1]};
        ivpos  = (int'(ivpos) >= IV_BITS) ? '0 : ivpos + 1'b1;
        keypos = keypos + 1'b1;
        if (ivpos == IVPOS_WINDOW_END && keypos == KEYPOS_WINDOW_END)
            past_window = 1'b1;
        return o;
    endfunction

    function automatic keystream_result_t predict_keystream(input logic item_op,
                                                            input logic [COUNT_W-1:0] count);
        keystream_result_t r;
        int unsigned n;
        r = '0;
        if (item_op == OP_INIT)
        begin
            for (int i = 0; i < LONG_LEN; i++)
                lreg[i] = key_bit(i);
            lreg[0] = ~lreg[0];
            for (int i = 0; i < SHORT_LEN; i++)
                sreg[i] = key_bit(i + LONG_LEN);
            ivpos       = '0;
            keypos      = '0;
            past_window = 1'b0;
            repeat (INIT_CLOCKS)
                void'(clock_registers(1'b1));
            r.done = 1'b1;
        end
        else
        begin
            n = (count > WORD_BITS) ? WORD_BITS : count;
            for (int i = 0; i < n; i++)
                r.word[WORD_BITS-1-i] = clock_registers(1'b0);
            r.count = n[COUNT_W-1:0];
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driving helpers
    // ------------------------------------------------------------------

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [COUNT_W-1:0] pick_count();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        if (r <= 2)
            return COUNT_W'($urandom_range(WORD_BITS + 1, COUNT_MAX));
        return COUNT_W'($urandom_range(1, WORD_BITS));
    endfunction

    // offer one transaction, return at the edge it is accepted with valid still high
    task automatic send_item(input logic item_op, input logic [COUNT_W-1:0] count);
        int unsigned gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 4) == 0)
            gap = $urandom_range(1, 17);
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        op        <= item_op;
        bit_count <= count;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_keystream.push_back(predict_keystream(item_op, count));
        items_sent++;
        if (item_op == OP_INIT)
            init_items++;
        else
            gen_items++;
    endtask

    // drop valid and wait until every expected result is in
    task automatic wait_for_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_keystream.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= data;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        case (idx)
            REG_KEY_HIGH: key_hi_m = data;
            REG_KEY_LOW:  key_lo_m = data;
            REG_IV_HIGH:  iv_hi_m  = data;
            REG_IV_LOW:   iv_lo_m  = data[31:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic load_key_iv(input logic [63:0] kh, input logic [63:0] kl,
                               input logic [63:0] ivh, input logic [63:0] ivl);
        wait_for_idle();
        write_cfg(REG_KEY_HIGH, kh);
        write_cfg(REG_KEY_LOW, kl);
        write_cfg(REG_IV_HIGH, ivh);
        write_cfg(REG_IV_LOW, ivl);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // generate straight out of reset: all-zero state exercises the escape term
    task automatic test_generate_from_reset();
        send_item(OP_GENERATE, COUNT_W'(WORD_BITS));
        send_item(OP_GENERATE, COUNT_W'(1));
        send_item(OP_GENERATE, '0);
        send_item(OP_GENERATE, COUNT_W'(COUNT_MAX));
        wait_for_idle();
    endtask

    task automatic test_key_extremes();
        load_key_iv('0, '0, '0, '0);
        send_item(OP_INIT, '0);
        send_item(OP_GENERATE, COUNT_W'(WORD_BITS));
        send_item(OP_GENERATE, COUNT_W'(17));
        // all ones, with upper IV-low data bits that must be dropped
        load_key_iv('1, '1, '1, '1);
        send_item(OP_INIT, COUNT_W'(COUNT_MAX));
        send_item(OP_GENERATE, COUNT_W'(WORD_BITS));
        send_item(OP_GENERATE, COUNT_W'(WORD_BITS + 1));
        wait_for_idle();
    endtask

    // writes past the register list must leave the key and IV alone
    task automatic test_ignored_indexes();
        load_key_iv(rand64(), rand64(), rand64(), rand64());
        for (int k = REG_UNUSED_FIRST; k <= REG_UNUSED_LAST; k++)
            write_cfg(k[CFG_INDEX_W-1:0], '1);
        send_item(OP_INIT, '0);
        send_item(OP_GENERATE, COUNT_W'(WORD_BITS));
        wait_for_idle();
    endtask

    // back-to-back initialize, then power-of-two counts from 1 to 32
    task automatic test_count_edges();
        send_item(OP_INIT, '0);
        send_item(OP_INIT, '0);
        for (int k = 0; k < COUNT_W; k++)
            send_item(OP_GENERATE, COUNT_W'(1 << k));
        wait_for_idle();
    endtask

    // receiver holds off while the sender keeps offering full-word generate transactions
    task automatic test_backpressure();
        idle_on = 1'b0;
        send_item(OP_INIT, '0);
        wait_for_idle();
        hold_asked++;
        for (int k = 0; k < 8; k++)
            send_item(OP_GENERATE, COUNT_W'(WORD_BITS));
        wait_for_idle();
    endtask

    task automatic run_session();
        int unsigned len;
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            load_key_iv('0, '0, '0, '0);
        else if (pick == 1)
            load_key_iv('1, '1, '1, '1);
        else if (pick <= 6)
            load_key_iv(rand64(), rand64(), rand64(), rand64());
        else if (pick == 7)
        begin
            wait_for_idle();
            write_cfg(CFG_INDEX_W'($urandom_range(REG_KEY_HIGH, REG_UNUSED_LAST)), rand64());
        end
        // most sessions start with an initialize; the rest continue the old state
        if ($urandom_range(0, 19) < 17)
            send_item(OP_INIT, COUNT_W'($urandom_range(0, COUNT_MAX)));
        len = $urandom_range(8, 40);
        for (int k = 0; k < len; k++)
        begin
            if ($urandom_range(0, 24) == 0)
                send_item(OP_INIT, COUNT_W'($urandom_range(0, COUNT_MAX)));
            else
                send_item(OP_GENERATE, pick_count());
        end
    endtask

    task automatic test_random_sessions();
        while (items_sent < RANDOM_TARGET)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            run_session();
        end
        wait_for_idle();
    endtask

    // last stretch: no idling on either side
    task automatic test_steady_stream();
        int unsigned stop_at;
        idle_on = 1'b0;
        load_key_iv(rand64(), rand64(), rand64(), rand64());
        stop_at = items_sent + STEADY_ITEMS;
        send_item(OP_INIT, '0);
        while (items_sent < stop_at)
            send_item(OP_GENERATE, pick_count());
        wait_for_idle();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        op           = OP_INIT;
        bit_count    = '0;
        cfg_write_en = 1'b0;
        cfg_index    = REG_KEY_HIGH;
        cfg_data     = '0;
        sreg         = '0;
        lreg         = '0;
        ivpos        = '0;
        keypos       = '0;
        past_window  = 1'b0;
        key_hi_m     = '0;
        key_lo_m     = '0;
        iv_hi_m      = '0;
        iv_lo_m      = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        idle_on = 1'b1;
        test_generate_from_reset();
        test_key_extremes();
        test_ignored_indexes();
        test_count_edges();
        test_backpressure();
        test_random_sessions();
        test_steady_stream();

        repeat (40) @(posedge clk);
        if (pending_keystream.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_keystream.size());
            fail_count++;
        end
        $display("covered %0d initialize and %0d generate transactions, %0d results checked",
                 init_items, gen_items, results_seen);
        $display("%0d register writes, key/IV extremes, ignored indexes, long output hold-off",
                 reg_writes);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // receiver: random stall bursts, plus the requested long hold-off
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_asked != hold_done)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_done++;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(0, 16)) @(negedge clk);
            end
            else
                out_stall <= 1'b0;
        end
    end

    // result checking against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_keystream.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $error("result with nothing expected: word %h count %0d done %b",
                           keystream_word, bits_produced, init_done);
            end
            else
            begin
                next_expected = pending_keystream.pop_front();
                if (keystream_word !== next_expected.word)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $error("keystream_word: expected %h, actual %h",
                               next_expected.word, keystream_word);
                end
                if (bits_produced !== next_expected.count)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $error("bits_produced: expected %0d, actual %0d",
                               next_expected.count, bits_produced);
                end
                if (init_done !== next_expected.done)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $error("init_done: expected %b, actual %b",
                               next_expected.done, init_done);
                end
            end
        end
    end

    // watchdog on cycles without any transaction or register write
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write_en)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout after %0d quiet cycles, %0d results outstanding",
                     quiet_cycles, pending_keystream.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule
